@@ hw/rtl/tcw_pkg.sv @@
// Package for the task check-in watchdog: field widths, register indexes,
// reset values, mode and transition codes. No dependencies.
`default_nettype none

package tcw_pkg;

  // Field widths.
  localparam int KICK_W     = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int THR_W      = 8;
  localparam int COUNT_W    = 8;
  localparam int MODE_W     = 2;
  localparam int TRANS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_NOMINAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_DEGRADED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_SAFE     = 3'd4;

  // Register reset values.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST       = 16'd1000;
  localparam logic [THR_W-1:0]     THRESHOLD_RST     = 8'd3;
  localparam logic [KICK_W-1:0]    MASK_NOMINAL_RST  = 8'h07;
  localparam logic [KICK_W-1:0]    MASK_DEGRADED_RST = 8'h07;
  localparam logic [KICK_W-1:0]    MASK_SAFE_RST     = 8'h01;

  // Input action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KICK = 1'b1;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_NOMINAL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEGRADED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAFE     = 2'd2;

  // Transition codes.
  localparam logic [TRANS_W-1:0] TRANS_NONE      = 2'd0;
  localparam logic [TRANS_W-1:0] TRANS_DEGRADED  = 2'd1;
  localparam logic [TRANS_W-1:0] TRANS_SAFE      = 2'd2;
  localparam logic [TRANS_W-1:0] TRANS_RECOVERED = 2'd3;

  // Payload of one result transfer.
  typedef struct packed {
    logic               window_ok;
    logic [KICK_W-1:0]  missing_bits;
    logic [MODE_W-1:0]  new_mode;
    logic [TRANS_W-1:0] transition;
    logic [COUNT_W-1:0] recovery_count;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_if.sv @@
// Handshake channels of the task check-in watchdog: item input, result
// output and configuration write. Depends on tcw_pkg.
`default_nettype none

// Input items: ticks and kicks.
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [KICK_W-1:0] kick_bits;

  modport source (output valid, output action, output kick_bits, input ready);
  modport sink (input valid, input action, input kick_bits, output ready);
endinterface

// Result items, one per closed window.
interface tcw_out_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               window_ok;
  logic [KICK_W-1:0]  missing_bits;
  logic [MODE_W-1:0]  new_mode;
  logic [TRANS_W-1:0] transition;
  logic [COUNT_W-1:0] recovery_count;

  modport source (output valid, output window_ok, output missing_bits,
                  output new_mode, output transition, output recovery_count,
                  input ready);
  modport sink (input valid, input window_ok, input missing_bits,
                input new_mode, input transition, input recovery_count,
                output ready);
endinterface

// Configuration register writes.
interface tcw_cfg_if import tcw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/task_checkin_watchdog.sv @@
// Top level of the task check-in watchdog: input register, window judge,
// mode state and result register. Depends on tcw_pkg and tcw_if.
//
//   Channel  Dir  Payload                                         Transfer
//   in_i     in   action, kick_bits                               valid & ready
//   out_o    out  window_ok, missing_bits, new_mode, transition,  valid & ready
//                 recovery_count
//   cfg_i    in   index, data                                     valid & ready
//
// One item per cycle sustained while results are taken. An item taken at
// a rising edge is held in the input register and judged from there; a
// closed window's result is loaded into the output register at the edge
// that ends its judgment. Reset clears the window, the mode (nominal) and
// loads the register defaults. A result that is not taken stalls the judge:
// the input register then holds its item and input ready drops.
`default_nettype none

module task_checkin_watchdog
  import tcw_pkg::*;
#(
  parameter int TASK_BITS  = 8,
  parameter int TICK_WIDTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tcw_in_if.sink      in_i,
  tcw_out_if.source   out_o,
  tcw_cfg_if.sink     cfg_i
);

  localparam logic [KICK_W-1:0] TaskMask = (TASK_BITS >= KICK_W) ? {KICK_W{1'b1}} :
      KICK_W'((64'd1 << TASK_BITS) - 64'd1);
  localparam logic [TICK_WIDTH-1:0] TickMax = {TICK_WIDTH{1'b1}};
  localparam int CmpW = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;
  localparam logic [COUNT_W-1:0] CountMax = {COUNT_W{1'b1}};

  // Configuration registers.
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [THR_W-1:0]     threshold_q;
  logic [KICK_W-1:0]    mask_nom_q, mask_deg_q, mask_safe_q;

  // Window and mode state.
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [KICK_W-1:0]     rcv_q, rcv_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;

  // Input register.
  logic              in_valid_q;
  logic              in_action_q;
  logic [KICK_W-1:0] in_kick_q;

  // Output register.
  logic    out_valid_q;
  result_t out_q, res_d;

  logic              proc;
  logic [KICK_W-1:0] expected;
  logic [KICK_W-1:0] rcv_next;
  logic [TICK_WIDTH-1:0] tick_next;
  logic [COUNT_W-1:0] cnt_inc;
  logic              hit, tmo, close_win;

  // The held item is judged when the output register can take a result.
  assign proc        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || proc;
  assign cfg_i.ready = 1'b1;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RST;
      threshold_q <= THRESHOLD_RST;
      mask_nom_q  <= MASK_NOMINAL_RST;
      mask_deg_q  <= MASK_DEGRADED_RST;
      mask_safe_q <= MASK_SAFE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TIMEOUT:       timeout_q   <= cfg_i.data;
        REG_THRESHOLD:     threshold_q <= cfg_i.data[THR_W-1:0];
        REG_MASK_NOMINAL:  mask_nom_q  <= cfg_i.data[KICK_W-1:0];
        REG_MASK_DEGRADED: mask_deg_q  <= cfg_i.data[KICK_W-1:0];
        REG_MASK_SAFE:     mask_safe_q <= cfg_i.data[KICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_action_q <= in_i.action;
      in_kick_q   <= in_i.kick_bits;
    end
  end

  // Expected bits of the current mode.
  always_comb begin
    case (mode_q)
      MODE_NOMINAL:  expected = mask_nom_q & TaskMask;
      MODE_DEGRADED: expected = mask_deg_q & TaskMask;
      default:       expected = mask_safe_q & TaskMask;
    endcase
  end

  // Window update and judgment for the held item.
  always_comb begin
    rcv_next  = rcv_q;
    tick_next = tick_q;
    if (in_action_q == ACT_KICK) begin
      rcv_next = rcv_q | (in_kick_q & TaskMask);
    end else if (tick_q != TickMax) begin
      tick_next = tick_q + 1'b1;
    end
    cnt_inc   = (cnt_q != CountMax) ? cnt_q + 1'b1 : cnt_q;
    hit       = (rcv_next & expected) == expected;
    tmo       = CmpW'(tick_next) >= CmpW'(timeout_q);
    close_win = hit || tmo;

    mode_d = mode_q;
    cnt_d  = cnt_q;
    res_d.window_ok    = hit;
    res_d.missing_bits = '0;
    res_d.transition   = TRANS_NONE;
    if (hit) begin
      if (mode_q == MODE_DEGRADED) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= threshold_q) begin
          mode_d           = MODE_NOMINAL;
          cnt_d            = '0;
          res_d.transition = TRANS_RECOVERED;
        end
      end else begin
        cnt_d = '0;
      end
    end else begin
      res_d.missing_bits = expected & ~rcv_next;
      if (mode_q == MODE_NOMINAL) begin
        mode_d           = MODE_DEGRADED;
        res_d.transition = TRANS_DEGRADED;
      end else if (mode_q == MODE_DEGRADED) begin
        mode_d           = MODE_SAFE;
        res_d.transition = TRANS_SAFE;
      end
    end
    res_d.new_mode       = mode_d;
    res_d.recovery_count = cnt_d;

    // A closed window starts empty.
    rcv_d  = close_win ? '0 : rcv_next;
    tick_d = close_win ? '0 : tick_next;
  end

  // Window registers advance once per judged item; mode and count change only when the window closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NOMINAL;
      rcv_q  <= '0;
      tick_q <= '0;
      cnt_q  <= '0;
    end else if (proc) begin
      rcv_q  <= rcv_d;
      tick_q <= tick_d;
      if (close_win) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && close_win) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && close_win) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.window_ok      = out_q.window_ok;
  assign out_o.missing_bits   = out_q.missing_bits;
  assign out_o.new_mode       = out_q.new_mode;
  assign out_o.transition     = out_q.transition;
  assign out_o.recovery_count = out_q.recovery_count;

  // Safe mode is never left.
  a_safe_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mode_q == MODE_SAFE |=> mode_q == MODE_SAFE)
    else $error("mode left safe");

  // A recovery reports nominal mode and a cleared count.
  a_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.transition == TRANS_RECOVERED |->
      out_q.new_mode == MODE_NOMINAL && out_q.recovery_count == '0 && out_q.window_ok)
    else $error("bad recovery result");

  // A successful window reports no missing bits.
  a_ok_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.window_ok |-> out_q.missing_bits == '0)
    else $error("success with missing bits");

  // A judged item that closes the window leaves it empty.
  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
      proc && close_win |=> rcv_q == '0 && tick_q == '0)
    else $error("window not cleared");

endmodule

`default_nettype wire
